// File: rtl/sorted_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Sorted Priority Queue Assertion Macros
// Shared concurrent assertion forms for the queue RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue: assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue: assertion failed");

`endif

// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted Priority Queue Package
// Constants, request codes, controller states and command/status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int PRI_W  = 32;

    localparam logic signed [PRI_W-1:0] EMPTY_PRI = -32'sd65536;

    typedef enum logic [1:0] {
        REQ_ENQ   = 2'd0,
        REQ_DEQ   = 2'd1,
        REQ_PEEK  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_START,
        S_ENQ_CMP,
        S_HEAD,
        S_CLEAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic set_ovf;
        logic rd_tail;
        logic shift;
        logic insert;
        logic pop;
        logic cap_head;
        logic clr;
        logic load_out;
    } t_spq_cmd;

    typedef struct packed {
        t_req req;
        logic full;
        logic empty;
        logic idx_zero;
        logic idx_one;
        logic less;
        logic out_free;
    } t_spq_sts;

endpackage

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted Priority Queue
// Bounded min-first queue kept in ascending priority order in a circular
// memory; newest entry goes first among equal priorities.
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_stall  i_req_type, i_item_value,
//                                           i_item_priority
//   result    out        o_valid / i_stall  o_head_value, o_head_priority,
//                                           o_was_empty, o_overflow,
//                                           o_entry_count
//
// Dequeue, peek, clear, and enqueue into a full or empty queue need no search;
// other enqueues search from the tail, shifting each entry with priority >= new;
// the memory moves one entry per cycle through its single write port.
// Synchronous active-low reset empties the queue; no memory clearing pass.
// A finished result waits in the output register while the next request
// is taken; i_stall holds it and only the final hand-off waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue import spq_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [1:0]              i_req_type,
    input  wire logic [VAL_W-1:0]        i_item_value,
    input  wire logic signed [PRI_W-1:0] i_item_priority,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [VAL_W-1:0]             o_head_value,
    output logic signed [PRI_W-1:0]      o_head_priority,
    output logic                         o_was_empty,
    output logic                         o_overflow,
    output logic [CNT_W-1:0]             o_entry_count
);

    t_spq_cmd w_cmd;
    t_spq_sts w_sts;
    t_req     w_req;
    logic     w_idle;

    assign w_req   = t_req'(i_req_type);
    assign o_stall = !w_idle;

    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (w_req),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_idle  (w_idle)
    );

    spq_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_req           (w_req),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .i_out_stall     (i_stall),
        .o_sts           (w_sts),
        .o_valid         (o_valid),
        .o_head_value    (o_head_value),
        .o_head_priority (o_head_priority),
        .o_was_empty     (o_was_empty),
        .o_overflow      (o_overflow),
        .o_entry_count   (o_entry_count)
    );

    `SPQ_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, o_valid, o_entry_count <= CNT_W'(DEPTH))
    `SPQ_ASSERT_IMPL(a_ovf_full, i_clk, i_rst_n, o_valid && o_overflow, o_entry_count == CNT_W'(DEPTH))
    `SPQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `SPQ_ASSERT_IMPL(a_one_update, i_clk, i_rst_n, 1'b1, $onehot0({w_cmd.insert, w_cmd.shift, w_cmd.pop, w_cmd.clr}))

endmodule

`default_nettype wire

// File: rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted Priority Queue Controller
// Sequences enqueue search/shift, head access, clear and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl import spq_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_req     i_req,
    input  wire t_spq_sts i_sts,
    output t_spq_cmd      o_cmd,
    output logic          o_idle
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_idle  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_req)
                        REQ_ENQ:   n_state = S_ENQ_START;
                        REQ_DEQ:   n_state = S_HEAD;
                        REQ_PEEK:  n_state = S_HEAD;
                        REQ_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ENQ_START: begin
                priority if (i_sts.full) begin
                    o_cmd.set_ovf = 1'b1;
                    n_state       = S_DONE;
                end else if (i_sts.idx_zero) begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.rd_tail = 1'b1;
                    n_state       = S_ENQ_CMP;
                end
            end
            S_ENQ_CMP: begin
                if (i_sts.less) begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.shift = 1'b1;
                    if (i_sts.idx_one) begin
                        n_state = S_ENQ_START;
                    end
                end
            end
            S_HEAD: begin
                o_cmd.cap_head = 1'b1;
                if (i_sts.req == REQ_DEQ && !i_sts.empty) begin
                    o_cmd.pop = 1'b1;
                end
                n_state = S_DONE;
            end
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/spq_dpath.sv
// ----------------------------------------------------------------------------
// Sorted Priority Queue Datapath
// Circular entry memory, head pointer, occupancy, search index, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_dpath import spq_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_spq_cmd                i_cmd,
    input  wire t_req                    i_req,
    input  wire logic [VAL_W-1:0]        i_item_value,
    input  wire logic signed [PRI_W-1:0] i_item_priority,
    input  wire logic                    i_out_stall,
    output t_spq_sts                     o_sts,
    output logic                         o_valid,
    output logic [VAL_W-1:0]             o_head_value,
    output logic signed [PRI_W-1:0]      o_head_priority,
    output logic                         o_was_empty,
    output logic                         o_overflow,
    output logic [CNT_W-1:0]             o_entry_count
);

    logic [VAL_W-1:0]        mem_val [DEPTH];
    logic signed [PRI_W-1:0] mem_pri [DEPTH];

    logic [ADDR_W-1:0]       r_head;
    logic [CNT_W-1:0]        r_occ;
    logic [CNT_W-1:0]        r_idx;
    t_req                    r_req;
    logic [VAL_W-1:0]        r_val;
    logic signed [PRI_W-1:0] r_pri;
    logic [VAL_W-1:0]        r_rd_val;
    logic signed [PRI_W-1:0] r_rd_pri;
    logic [VAL_W-1:0]        r_hv;
    logic signed [PRI_W-1:0] r_hp;
    logic                    r_was_empty;
    logic                    r_ovf;

    logic                    r_out_valid;
    logic [VAL_W-1:0]        r_out_hv;
    logic signed [PRI_W-1:0] r_out_hp;
    logic                    r_out_empty;
    logic                    r_out_ovf;
    logic [CNT_W-1:0]        r_out_cnt;

    logic [ADDR_W-1:0]       w_pos;
    logic [ADDR_W-1:0]       w_rd_addr;
    logic                    w_empty;

    assign w_pos   = r_head + r_idx[ADDR_W-1:0];
    assign w_empty = (r_occ == '0);

    always_comb begin
        priority if (i_cmd.shift) begin
            w_rd_addr = w_pos - ADDR_W'(2);
        end else if (i_cmd.rd_tail) begin
            w_rd_addr = w_pos - ADDR_W'(1);
        end else begin
            w_rd_addr = r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            mem_val[w_pos] <= r_val;
            mem_pri[w_pos] <= r_pri;
        end else if (i_cmd.shift) begin
            mem_val[w_pos] <= r_rd_val;
            mem_pri[w_pos] <= r_rd_pri;
        end
        r_rd_val <= mem_val[w_rd_addr];
        r_rd_pri <= mem_pri[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_occ  <= '0;
        end else begin
            priority if (i_cmd.clr) begin
                r_occ <= '0;
            end else if (i_cmd.insert) begin
                r_occ <= r_occ + CNT_W'(1);
            end else if (i_cmd.pop) begin
                r_occ  <= r_occ - CNT_W'(1);
                r_head <= r_head + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req       <= i_req;
            r_val       <= i_item_value;
            r_pri       <= i_item_priority;
            r_idx       <= r_occ;
            r_was_empty <= w_empty;
            r_ovf       <= 1'b0;
            r_hv        <= '0;
            r_hp        <= '0;
        end else begin
            if (i_cmd.shift) begin
                r_idx <= r_idx - CNT_W'(1);
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.cap_head) begin
                r_hv <= w_empty ? '0 : r_rd_val;
                r_hp <= w_empty ? EMPTY_PRI : r_rd_pri;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_hv    <= r_hv;
            r_out_hp    <= r_hp;
            r_out_empty <= r_was_empty;
            r_out_ovf   <= r_ovf;
            r_out_cnt   <= r_occ;
        end
    end

    always_comb begin
        o_sts.req      = r_req;
        o_sts.full     = (r_occ == CNT_W'(DEPTH));
        o_sts.empty    = w_empty;
        o_sts.idx_zero = (r_idx == '0);
        o_sts.idx_one  = (r_idx == CNT_W'(1));
        o_sts.less     = (r_rd_pri < r_pri);
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_valid         = r_out_valid;
    assign o_head_value    = r_out_hv;
    assign o_head_priority = r_out_hp;
    assign o_was_empty     = r_out_empty;
    assign o_overflow      = r_out_ovf;
    assign o_entry_count   = r_out_cnt;

endmodule

`default_nettype wire
